[rtl/core/tli_pkg.sv]
`timescale 1ns / 1ps

package tli_pkg;

  typedef struct packed {
    logic               action;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_x;
    logic [16:0]        entry_cdf;
    logic [31:0]        entry_pdf;
    logic signed [31:0] query_point;
  } in_t;

  typedef struct packed {
    logic [16:0] cdf_value;
    logic [31:0] pdf_value;
    logic        below_range;
    logic        above_range;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic [16:0]        cdf;
    logic [31:0]        pdf;
  } entry_t;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_ENTRIES = 1'b0,
    CFG_PDF_SCALE     = 1'b1
  } cfg_idx_e;

  localparam logic        ACTION_LOAD       = 1'b0;
  localparam logic        ACTION_QUERY      = 1'b1;
  localparam logic [10:0] TABLE_ENTRIES_RST = 11'd2;
  localparam logic [31:0] PDF_SCALE_RST     = 32'd65536;
  localparam logic [16:0] CDF_UNITY         = 17'd65536;
  localparam logic [6:0]  DIV_STEPS         = 7'd64;

  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_ONE,
    ADDR_LAST,
    ADDR_NEXT
  } addr_sel_e;

  typedef enum logic [1:0] {
    MUL_CDF,
    MUL_PDF,
    MUL_SCALE
  } mul_sel_e;

  typedef enum logic [2:0] {
    CDF_HOLD,
    CDF_ZERO,
    CDF_SET_ONE,
    CDF_LEFT,
    CDF_LERP
  } cdf_op_e;

  typedef enum logic [1:0] {
    PDF_HOLD,
    PDF_LEFT,
    PDF_RDATA,
    PDF_LERP
  } pdf_op_e;

  typedef struct packed {
    logic      mem_we;
    logic      query_load;
    addr_sel_e addr_sel;
    logic      left_load;
    logic      cur_set_one;
    logic      cur_inc;
    logic      flags_load;
    logic      setup_load;
    logic      acc_load;
    logic      div_step;
    mul_sel_e  mul_sel;
    cdf_op_e   cdf_op;
    pdf_op_e   pdf_op;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic below;
    logic above;
    logic search_go;
    logic degenerate;
    logic div_last;
  } sts_t;

endpackage

[rtl/core/tli_ctrl.sv]
`timescale 1ns / 1ps

module tli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_action_i,
  output logic          in_stall_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  input  tli_pkg::sts_t sts_i,
  output tli_pkg::cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_RD_FIRST = 12'b0000_0000_0010,
    S_RD_LAST  = 12'b0000_0000_0100,
    S_CHECK    = 12'b0000_0000_1000,
    S_SEARCH   = 12'b0000_0001_0000,
    S_MUL_C    = 12'b0000_0010_0000,
    S_DIV_C    = 12'b0000_0100_0000,
    S_MUL_P    = 12'b0000_1000_0000,
    S_DIV_P    = 12'b0001_0000_0000,
    S_LERP_P   = 12'b0010_0000_0000,
    S_SCALE    = 12'b0100_0000_0000,
    S_SAT      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.addr_sel = tli_pkg::ADDR_ZERO;
    cmd_o.mul_sel  = tli_pkg::MUL_CDF;
    cmd_o.cdf_op   = tli_pkg::CDF_HOLD;
    cmd_o.pdf_op   = tli_pkg::PDF_HOLD;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_action_i == tli_pkg::ACTION_LOAD) begin
            cmd_o.mem_we = 1'b1;
          end else begin
            cmd_o.query_load = 1'b1;
            state_d = S_RD_FIRST;
          end
        end
      end
      S_RD_FIRST: begin
        cmd_o.addr_sel = tli_pkg::ADDR_ZERO;
        state_d = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd_o.addr_sel  = tli_pkg::ADDR_LAST;
        cmd_o.left_load = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.addr_sel    = tli_pkg::ADDR_ONE;
        cmd_o.cur_set_one = 1'b1;
        cmd_o.flags_load  = 1'b1;
        if (sts_i.below) begin
          cmd_o.cdf_op = tli_pkg::CDF_ZERO;
          cmd_o.pdf_op = tli_pkg::PDF_LEFT;
          state_d = S_SCALE;
        end else if (sts_i.above) begin
          cmd_o.cdf_op = tli_pkg::CDF_SET_ONE;
          cmd_o.pdf_op = tli_pkg::PDF_RDATA;
          state_d = S_SCALE;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.addr_sel = tli_pkg::ADDR_NEXT;
        if (sts_i.search_go) begin
          cmd_o.left_load = 1'b1;
          cmd_o.cur_inc   = 1'b1;
        end else begin
          cmd_o.setup_load = 1'b1;
          if (sts_i.degenerate) begin
            cmd_o.cdf_op = tli_pkg::CDF_LEFT;
            cmd_o.pdf_op = tli_pkg::PDF_LEFT;
            state_d = S_SCALE;
          end else begin
            state_d = S_MUL_C;
          end
        end
      end
      S_MUL_C: begin
        cmd_o.mul_sel  = tli_pkg::MUL_CDF;
        cmd_o.acc_load = 1'b1;
        state_d = S_DIV_C;
      end
      S_DIV_C: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_MUL_P;
        end
      end
      S_MUL_P: begin
        cmd_o.cdf_op   = tli_pkg::CDF_LERP;
        cmd_o.mul_sel  = tli_pkg::MUL_PDF;
        cmd_o.acc_load = 1'b1;
        state_d = S_DIV_P;
      end
      S_DIV_P: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_LERP_P;
        end
      end
      S_LERP_P: begin
        cmd_o.pdf_op = tli_pkg::PDF_LERP;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.mul_sel  = tli_pkg::MUL_SCALE;
        cmd_o.acc_load = 1'b1;
        state_d = S_SAT;
      end
      S_SAT: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/tli_dpath.sv]
`timescale 1ns / 1ps

module tli_dpath #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tli_pkg::in_t                       in_data_i,
  input  logic                               cfg_we_i,
  input  logic [tli_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tli_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  tli_pkg::cmd_t                      cmd_i,
  output tli_pkg::sts_t                      sts_o,
  output tli_pkg::out_t                      out_data_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [10:0]           entries_q;
  logic [31:0]           scale_q;
  logic [31:0]           entries_w;
  logic [AW-1:0]         last_cfg;

  tli_pkg::entry_t       table_q [TABLE_DEPTH];
  tli_pkg::entry_t       rd_q;
  tli_pkg::entry_t       left_q;
  tli_pkg::entry_t       wr_entry;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;

  logic signed [31:0]    q_q;
  logic [AW-1:0]         last_q;
  logic [AW-1:0]         cur_q;

  logic [32:0]           d_full;
  logic [32:0]           w_full;
  logic [31:0]           d_clip;
  logic [31:0]           d_q;
  logic [31:0]           w_q;
  logic [16:0]           span_c_q;
  logic [31:0]           span_p_q;
  logic                  c_up_q;
  logic                  p_up_q;

  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           mul_p;
  logic [63:0]           acc_q;
  logic [31:0]           rem_q;
  logic [31:0]           rem_d;
  logic [6:0]            cnt_q;
  logic [32:0]           shifted;
  logic                  ge;

  logic [16:0]           cdf_val_q;
  logic [31:0]           pdf_val_q;
  logic                  below_q;
  logic                  above_q;
  tli_pkg::out_t         out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= tli_pkg::TABLE_ENTRIES_RST;
      scale_q   <= tli_pkg::PDF_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tli_pkg::CFG_TABLE_ENTRIES: entries_q <= cfg_data_i[10:0];
        tli_pkg::CFG_PDF_SCALE:     scale_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign entries_w = 32'(entries_q);

  always_comb begin
    if (entries_w < 32'd2) begin
      last_cfg = AW'(1);
    end else if (entries_w > TABLE_DEPTH) begin
      last_cfg = AW'(TABLE_DEPTH - 1);
    end else begin
      last_cfg = AW'(entries_w - 32'd1);
    end
  end

  assign wr_en   = cmd_i.mem_we && (32'(in_data_i.entry_index) < TABLE_DEPTH);
  assign wr_addr = AW'(in_data_i.entry_index);

  always_comb begin
    wr_entry     = '0;
    wr_entry.x   = in_data_i.entry_x;
    wr_entry.cdf = in_data_i.entry_cdf;
    wr_entry.pdf = in_data_i.entry_pdf;
  end

  always_comb begin
    case (cmd_i.addr_sel)
      tli_pkg::ADDR_ZERO: rd_addr = '0;
      tli_pkg::ADDR_ONE:  rd_addr = AW'(1);
      tli_pkg::ADDR_LAST: rd_addr = last_q;
      tli_pkg::ADDR_NEXT: rd_addr = (cur_q == last_q) ? last_q : cur_q + AW'(1);
      default:            rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[wr_addr] <= wr_entry;
    end
    rd_q <= table_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_load) begin
      q_q    <= in_data_i.query_point;
      last_q <= last_cfg;
    end
    if (cmd_i.left_load) begin
      left_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (cmd_i.cur_set_one) begin
      cur_q <= AW'(1);
    end else if (cmd_i.cur_inc) begin
      cur_q <= cur_q + AW'(1);
    end
  end

  assign sts_o.below      = ($signed(q_q) <= $signed(left_q.x));
  assign sts_o.above      = ($signed(q_q) >= $signed(rd_q.x));
  assign sts_o.search_go  = (cur_q != last_q) && ($signed(rd_q.x) < $signed(q_q));
  assign sts_o.degenerate = ($signed(rd_q.x) <= $signed(left_q.x)) ||
                            ($signed(q_q) <= $signed(left_q.x));
  assign sts_o.div_last   = (cnt_q == 7'd1);

  // Offsets are only used when the interval is non-degenerate, so both are positive.
  assign d_full = {q_q[31], q_q} - {left_q.x[31], left_q.x};
  assign w_full = {rd_q.x[31], rd_q.x} - {left_q.x[31], left_q.x};
  assign d_clip = (d_full[31:0] > w_full[31:0]) ? w_full[31:0] : d_full[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup_load) begin
      d_q      <= d_clip;
      w_q      <= w_full[31:0];
      c_up_q   <= (rd_q.cdf >= left_q.cdf);
      p_up_q   <= (rd_q.pdf >= left_q.pdf);
      span_c_q <= (rd_q.cdf >= left_q.cdf) ? rd_q.cdf - left_q.cdf : left_q.cdf - rd_q.cdf;
      span_p_q <= (rd_q.pdf >= left_q.pdf) ? rd_q.pdf - left_q.pdf : left_q.pdf - rd_q.pdf;
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      tli_pkg::MUL_CDF: begin
        mul_a = d_q;
        mul_b = 32'(span_c_q);
      end
      tli_pkg::MUL_PDF: begin
        mul_a = d_q;
        mul_b = span_p_q;
      end
      tli_pkg::MUL_SCALE: begin
        mul_a = pdf_val_q;
        mul_b = scale_q;
      end
      default: begin
        mul_a = d_q;
        mul_b = 32'(span_c_q);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Restoring division, one quotient bit per cycle; the dividend shifts out of the
  // accumulator while the quotient shifts in.
  assign shifted = {rem_q, acc_q[63]};
  assign ge      = (shifted >= {1'b0, w_q});
  assign rem_d   = ge ? 32'(shifted - {1'b0, w_q}) : shifted[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.acc_load) begin
      cnt_q <= tli_pkg::DIV_STEPS;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) begin
      acc_q <= mul_p;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      acc_q <= {acc_q[62:0], ge};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.cdf_op)
      tli_pkg::CDF_ZERO:    cdf_val_q <= '0;
      tli_pkg::CDF_SET_ONE: cdf_val_q <= tli_pkg::CDF_UNITY;
      tli_pkg::CDF_LEFT:    cdf_val_q <= left_q.cdf;
      tli_pkg::CDF_LERP:    cdf_val_q <= c_up_q ? left_q.cdf + acc_q[16:0]
                                                : left_q.cdf - acc_q[16:0];
      default: begin
      end
    endcase
    case (cmd_i.pdf_op)
      tli_pkg::PDF_LEFT:  pdf_val_q <= left_q.pdf;
      tli_pkg::PDF_RDATA: pdf_val_q <= rd_q.pdf;
      tli_pkg::PDF_LERP:  pdf_val_q <= p_up_q ? left_q.pdf + acc_q[31:0]
                                              : left_q.pdf - acc_q[31:0];
      default: begin
      end
    endcase
    if (cmd_i.flags_load) begin
      below_q <= sts_o.below;
      above_q <= sts_o.above;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.cdf_value   <= (cdf_val_q > tli_pkg::CDF_UNITY) ? tli_pkg::CDF_UNITY : cdf_val_q;
      out_q.pdf_value   <= (acc_q[63:48] != 16'd0) ? 32'hFFFF_FFFF : acc_q[47:16];
      out_q.below_range <= below_q;
      out_q.above_range <= above_q;
    end
  end

  assign out_data_o = out_q;

endmodule

[rtl/core/table_linear_interpolator.sv]
`timescale 1ns / 1ps

// Piecewise linear lookup of a cumulative and a density value over a loaded table.
// The input channel (in_valid_i, in_stall_o, in_data_i) carries two kinds of beat.
// A load beat writes one table entry if its index is below TABLE_DEPTH and produces no output beat.
// A query beat searches the table from the start for its interval, interpolates the
// cumulative and density values, scales the density and produces one output beat on
// out_valid_o / out_data_o. A zero-width interval skips the divisions, and queries
// outside the table skip the search and the divisions.
// The search reads one table entry per cycle, and one restoring divider is shared by
// the two interpolations.
// One query is in flight at a time; in_stall_o is high until its result is in the
// output register, and the next beat is taken while that result still waits.
// If the receiver stalls, the result holds and the finished query waits before its
// register, so the input stays stalled behind it.
// Reset clears the control and sets table_entries to 2 and pdf_scale to one; the table
// itself is not cleared and must be loaded before use. The user must make configuration
// writes through cfg_we_i only while no query is in flight; the block does not enforce it.

module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  tli_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tli_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [tli_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tli_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tli_pkg::cmd_t cmd;
  tli_pkg::sts_t sts;

  tli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tli_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
